// ===== rtl/big_endian_memory_map_access_top_macros.svh =====
// assertion macros shared by the memory map access block
`ifndef BIG_ENDIAN_MEMORY_MAP_ACCESS_TOP_MACROS_SVH
`define BIG_ENDIAN_MEMORY_MAP_ACCESS_TOP_MACROS_SVH

// same-cycle implication, checked on clk, off while rst_n is low
`define BEMA_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("memory map access check failed");

// next-cycle implication
`define BEMA_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("memory map access check failed");

`endif

// ===== rtl/bema_pkg.sv =====
// shared constants, types and helpers of the memory map access block
package bema_pkg;

    localparam int RAM_ADDR_BITS  = 16;
    localparam int L2_ADDR_BITS   = 14;

    // each store is split into an even-word bank and an odd-word bank
    localparam int RAM_BANK_BITS  = RAM_ADDR_BITS - 3;
    localparam int L2_BANK_BITS   = L2_ADDR_BITS - 3;
    localparam int RAM_BANK_DEPTH = 2 ** RAM_BANK_BITS;
    localparam int L2_BANK_DEPTH  = 2 ** L2_BANK_BITS;
    localparam int CLR_BITS       = (RAM_BANK_BITS > L2_BANK_BITS) ? RAM_BANK_BITS
                                                                   : L2_BANK_BITS;

    localparam logic [31:0] FB_BASE  = 32'hC800_0000;
    localparam logic [31:0] DEV_BASE = 32'hCC00_0000;
    localparam logic [31:0] L2_BASE  = 32'hE000_0000;
    localparam logic [31:0] ROM_BASE = 32'hF000_0000;

    localparam logic [2:0] REGION_RAM = 3'd0;
    localparam logic [2:0] REGION_FB  = 3'd1;
    localparam logic [2:0] REGION_DEV = 3'd2;
    localparam logic [2:0] REGION_L2  = 3'd3;
    localparam logic [2:0] REGION_ROM = 3'd4;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE  = 2'd0;
    localparam logic [1:0] SIZE_HALF  = 2'd1;
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    localparam int IN_WIDTH  = 104;
    localparam int OUT_WIDTH = 72;

    typedef struct packed {
        logic                     op;
        logic [1:0]               size;
        logic [2:0]               region;
        logic                     invalid;
        logic                     sel_ram;
        logic                     sel_l2;
        logic [1:0]               lane;
        logic                     w0_odd;
        logic [63:0]              data;
        logic [RAM_BANK_BITS-1:0] ram_even_idx;
        logic [RAM_BANK_BITS-1:0] ram_odd_idx;
        logic [L2_BANK_BITS-1:0]  l2_even_idx;
        logic [L2_BANK_BITS-1:0]  l2_odd_idx;
    } access_t;

    // right shift that brings the top access bytes of a 64-bit window down
    function automatic logic [5:0] size_shift(input logic [1:0] size);
        logic [5:0] sh;
        unique case (size)
            SIZE_BYTE:  sh = 6'd56;
            SIZE_HALF:  sh = 6'd48;
            SIZE_WORD:  sh = 6'd32;
            SIZE_DWORD: sh = 6'd0;
            default:    sh = 6'd0;
        endcase
        return sh;
    endfunction

endpackage

// ===== rtl/bema_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module bema_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bema_decode.sv =====
// region decode and bank index generation for one access
module bema_decode (
    input  logic [bema_pkg::IN_WIDTH-1:0] in_data,
    output bema_pkg::access_t             item
);
    import bema_pkg::*;

    logic [1:0]                 size;
    logic [31:0]                addr;
    logic                       dword;
    logic [RAM_ADDR_BITS-3:0]   ram_w0;
    logic [L2_ADDR_BITS-3:0]    l2_w0;

    assign size   = in_data[2:1];
    assign addr   = in_data[34:3];
    assign dword  = (size == SIZE_DWORD);
    assign ram_w0 = addr[RAM_ADDR_BITS-1:2];
    assign l2_w0  = addr[L2_ADDR_BITS-1:2];

    always_comb
    begin
        item         = '0;
        item.op      = in_data[0];
        item.size    = size;
        item.data    = in_data[98:35];
        item.lane    = dword ? 2'b00 : addr[1:0];
        item.w0_odd  = addr[2];

        priority if (dword || addr < FB_BASE)
        begin
            item.region  = REGION_RAM;
            item.sel_ram = 1'b1;
        end
        else if (addr < DEV_BASE)
        begin
            item.region  = REGION_FB;
            item.invalid = 1'b1;
        end
        else if (addr < L2_BASE)
        begin
            item.region = REGION_DEV;
        end
        else if (addr < ROM_BASE)
        begin
            item.region = REGION_L2;
            item.sel_l2 = 1'b1;
        end
        else
        begin
            item.region = REGION_ROM;
        end

        // an access spans word w0 and w0+1; the even bank takes whichever is even
        item.ram_odd_idx  = ram_w0[RAM_ADDR_BITS-3:1];
        item.ram_even_idx = ram_w0[RAM_ADDR_BITS-3:1] + RAM_BANK_BITS'(ram_w0[0]);
        item.l2_odd_idx   = l2_w0[L2_ADDR_BITS-3:1];
        item.l2_even_idx  = l2_w0[L2_ADDR_BITS-3:1] + L2_BANK_BITS'(l2_w0[0]);
    end

endmodule

// ===== rtl/bema_merge.sv =====
// big-endian byte extraction and read-modify-write merge over a two-word window
module bema_merge (
    input  bema_pkg::access_t item,
    input  logic [31:0]       even_word,
    input  logic [31:0]       odd_word,
    output logic [63:0]       read_value,
    output logic [31:0]       wr_even,
    output logic [31:0]       wr_odd
);
    import bema_pkg::*;

    logic [63:0] window;
    logic [63:0] rd_raw;
    logic [63:0] wr_bytes;
    logic [63:0] wr_mask;
    logic [63:0] merged;
    logic [5:0]  sz_sh;
    logic [4:0]  lane_sh;

    // first word of the access in the top half, like a big-endian byte stream
    assign window   = item.w0_odd ? {odd_word, even_word} : {even_word, odd_word};
    assign sz_sh    = size_shift(item.size);
    assign lane_sh  = {item.lane, 3'b000};

    assign rd_raw   = (window << lane_sh) >> sz_sh;
    assign wr_bytes = (item.data << sz_sh) >> lane_sh;
    assign wr_mask  = ({64{1'b1}} << sz_sh) >> lane_sh;
    assign merged   = (window & ~wr_mask) | (wr_bytes & wr_mask);

    assign read_value = (item.op == OP_READ && (item.sel_ram || item.sel_l2)) ? rd_raw
                                                                              : 64'd0;
    assign wr_even    = item.w0_odd ? merged[31:0]  : merged[63:32];
    assign wr_odd     = item.w0_odd ? merged[63:32] : merged[31:0];

endmodule

// ===== rtl/big_endian_memory_map_access_top.sv =====
// top level of the big-endian memory map access block
//
//  channel   direction  tdata fields (lsb first)
//  s_axis    in         op, access_size, address, write_data, 5 pad bits
//  m_axis    out        read_data, region, invalid_access, 4 pad bits
//
// each access is handled in two steps: bank read on acceptance in ST_IDLE, then
// merge and write-back in ST_EXEC; no further access is accepted until the
// current one leaves ST_EXEC. after reset a clearing pass over every bank index
// zeroes both stores; no transaction is accepted during it.
// a result held on m_axis lets one further access be accepted, which then
// waits in its write-back cycle until the output register frees.
`include "big_endian_memory_map_access_top_macros.svh"

module big_endian_memory_map_access_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op, access_size, address, write_data, zero pad
    input  logic [bema_pkg::IN_WIDTH-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_data, region, invalid_access, zero pad
    output logic [bema_pkg::OUT_WIDTH-1:0] m_tdata
);
    import bema_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [CLR_BITS-1:0]  clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_WIDTH-1:0] out_data_reg, out_data_next;
    access_t              item_reg, item_next;
    access_t              dec_item;

    logic                 accept;
    logic                 done;
    logic                 clearing;
    logic                 ram_clr, l2_clr;
    logic                 ram_wr, l2_wr;

    logic [31:0]          ram_even_q, ram_odd_q, l2_even_q, l2_odd_q;
    logic [31:0]          sel_even, sel_odd;
    logic [63:0]          read_value;
    logic [31:0]          wr_even, wr_odd;

    logic [RAM_BANK_BITS-1:0] ram_even_wa, ram_odd_wa;
    logic [L2_BANK_BITS-1:0]  l2_even_wa, l2_odd_wa;
    logic [31:0]              ram_even_wd, ram_odd_wd, l2_even_wd, l2_odd_wd;

    bema_decode u_decode (
        .in_data (s_tdata),
        .item    (dec_item)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);
    assign clearing = (state_reg == ST_CLEAR);
    assign ram_clr  = clearing &&
                      ({1'b0, clr_reg} < (CLR_BITS + 1)'(RAM_BANK_DEPTH));
    assign l2_clr   = clearing &&
                      ({1'b0, clr_reg} < (CLR_BITS + 1)'(L2_BANK_DEPTH));
    assign ram_wr   = done && item_reg.op == OP_WRITE && item_reg.sel_ram;
    assign l2_wr    = done && item_reg.op == OP_WRITE && item_reg.sel_l2;

    assign sel_even = item_reg.sel_l2 ? l2_even_q : ram_even_q;
    assign sel_odd  = item_reg.sel_l2 ? l2_odd_q  : ram_odd_q;

    bema_merge u_merge (
        .item       (item_reg),
        .even_word  (sel_even),
        .odd_word   (sel_odd),
        .read_value (read_value),
        .wr_even    (wr_even),
        .wr_odd     (wr_odd)
    );

    // write port: clearing sweep or write-back of the current access
    assign ram_even_wa = clearing ? clr_reg[RAM_BANK_BITS-1:0] : item_reg.ram_even_idx;
    assign ram_odd_wa  = clearing ? clr_reg[RAM_BANK_BITS-1:0] : item_reg.ram_odd_idx;
    assign l2_even_wa  = clearing ? clr_reg[L2_BANK_BITS-1:0]  : item_reg.l2_even_idx;
    assign l2_odd_wa   = clearing ? clr_reg[L2_BANK_BITS-1:0]  : item_reg.l2_odd_idx;
    assign ram_even_wd = clearing ? 32'd0 : wr_even;
    assign ram_odd_wd  = clearing ? 32'd0 : wr_odd;
    assign l2_even_wd  = clearing ? 32'd0 : wr_even;
    assign l2_odd_wd   = clearing ? 32'd0 : wr_odd;

    bema_ram #(.WIDTH(32), .DEPTH(RAM_BANK_DEPTH)) u_ram_even (
        .clk     (clk),
        .rd_en   (accept && dec_item.sel_ram),
        .rd_addr (dec_item.ram_even_idx),
        .rd_data (ram_even_q),
        .wr_en   (ram_clr || ram_wr),
        .wr_addr (ram_even_wa),
        .wr_data (ram_even_wd)
    );

    bema_ram #(.WIDTH(32), .DEPTH(RAM_BANK_DEPTH)) u_ram_odd (
        .clk     (clk),
        .rd_en   (accept && dec_item.sel_ram),
        .rd_addr (dec_item.ram_odd_idx),
        .rd_data (ram_odd_q),
        .wr_en   (ram_clr || ram_wr),
        .wr_addr (ram_odd_wa),
        .wr_data (ram_odd_wd)
    );

    bema_ram #(.WIDTH(32), .DEPTH(L2_BANK_DEPTH)) u_l2_even (
        .clk     (clk),
        .rd_en   (accept && dec_item.sel_l2),
        .rd_addr (dec_item.l2_even_idx),
        .rd_data (l2_even_q),
        .wr_en   (l2_clr || l2_wr),
        .wr_addr (l2_even_wa),
        .wr_data (l2_even_wd)
    );

    bema_ram #(.WIDTH(32), .DEPTH(L2_BANK_DEPTH)) u_l2_odd (
        .clk     (clk),
        .rd_en   (accept && dec_item.sel_l2),
        .rd_addr (dec_item.l2_odd_idx),
        .rd_data (l2_odd_q),
        .wr_en   (l2_clr || l2_wr),
        .wr_addr (l2_odd_wa),
        .wr_data (l2_odd_wd)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        item_next      = item_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {CLR_BITS{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = dec_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0000, item_reg.invalid, item_reg.region, read_value};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // the invalid flag is set exactly when the region field reads frame-buffer
    `BEMA_ASSERT_IMP(a_invalid_region, m_tvalid, (m_tdata[67] == (m_tdata[66:64] == REGION_FB)))
    // stores are written only by the clearing sweep or a completing write-back
    `BEMA_ASSERT_IMP(a_wr_only_clr_or_exec, (ram_clr || ram_wr || l2_clr || l2_wr), (clearing || done))
    // an accepted transaction moves to write-back with its read data arriving
    `BEMA_ASSERT_NXT(a_accept_to_exec, accept, (state_reg == ST_EXEC))
    // doubleword accesses always land in main ram
    `BEMA_ASSERT_NXT(a_dword_ram, (accept && s_tdata[2:1] == SIZE_DWORD), (item_reg.sel_ram && !item_reg.sel_l2 && item_reg.region == REGION_RAM))

endmodule
